// ===== hdl/fpa_pkg.sv =====
// Package for the fixed-point ALU: the command codes and the control word
// that travels with each transaction along the cell chain. No dependencies.
package fpa_pkg;

    localparam int unsigned FIELD_WIDTH = 32;
    localparam int unsigned CMD_WIDTH   = 3;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_ADD,
        CMD_SUB,
        CMD_MUL,
        CMD_DIV,
        CMD_INC,
        CMD_DEC,
        CMD_MIN,
        CMD_MAX
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic neg;
        logic b_zero;
        logic gt;
        logic lt;
        logic eq;
    } ctl_t;

endpackage

// ===== hdl/fpa_if.sv =====
// Valid/ready channel interfaces for the operand and result transactions.
// Depends on fpa_pkg for the field widths.
interface fpa_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [fpa_pkg::CMD_WIDTH-1:0]           command;
    logic signed [fpa_pkg::FIELD_WIDTH-1:0]  operand_a;
    logic signed [fpa_pkg::FIELD_WIDTH-1:0]  operand_b;

    modport source (output valid, command, operand_a, operand_b, input ready);
    modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [fpa_pkg::FIELD_WIDTH-1:0]  result;
    logic                                    a_greater;
    logic                                    a_less;
    logic                                    a_equal;

    modport source (output valid, result, a_greater, a_less, a_equal, input ready);
    modport sink   (input valid, result, a_greater, a_less, a_equal, output ready);
endinterface

// ===== hdl/fixed_point_alu.sv =====
// Top level of the signed fixed-point ALU: operand decode, the cell chain and
// the output stage. Depends on fpa_pkg, fpa_if, fpa_cell and fpa_finish.
//
//   channel   | modport | fields
//   ----------+---------+---------------------------------------------
//   operands  | sink    | command, operand_a, operand_b
//   results   | source  | result, a_greater, a_less, a_equal
//
// One transaction is accepted per cycle unless the chain is stalled; each
// passes through the chain of one cell per quotient bit of the restoring
// divider and then through the output register.
// A stalled result holds its own register only; empty cells upstream still
// fill, so operands keep being accepted until the chain is full.
// Reset clears the valid bits of every cell and of the output register.
module fixed_point_alu #(
    parameter int unsigned FRACTION_BITS = 8,
    parameter int unsigned WORD_WIDTH    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    fpa_in_if.sink      operands,
    fpa_out_if.source   results
);

    localparam int unsigned W  = WORD_WIDTH;
    localparam int unsigned DW = WORD_WIDTH + FRACTION_BITS;
    localparam int unsigned N  = DW;
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

    logic                 v   [0:N];
    fpa_pkg::ctl_t        ctl [0:N];
    logic [W-1:0]         smp [0:N];
    logic [W-1:0]         ma  [0:N];
    logic [W-1:0]         mb  [0:N];
    logic [W-1:0]         hi  [0:N];
    logic [W-1:0]         lo  [0:N];
    logic [W-1:0]         rem [0:N];
    logic [DW-1:0]        dq  [0:N];
    logic                 rdy [0:N];

    logic signed [W-1:0]  a_w;
    logic signed [W-1:0]  b_w;
    fpa_pkg::cmd_t        cmd;

    always_comb
    begin
        a_w = W'(operands.operand_a);
        b_w = W'(operands.operand_b);
        cmd = fpa_pkg::cmd_t'(operands.command);
        ctl[0].cmd    = cmd;
        ctl[0].neg    = a_w[W-1] ^ b_w[W-1];
        ctl[0].b_zero = b_w == {W{1'b0}};
        ctl[0].gt     = a_w > b_w;
        ctl[0].lt     = a_w < b_w;
        ctl[0].eq     = a_w == b_w;
        case (cmd)
            fpa_pkg::CMD_ADD: smp[0] = a_w + b_w;
            fpa_pkg::CMD_SUB: smp[0] = a_w - b_w;
            fpa_pkg::CMD_INC: smp[0] = a_w + ONE;
            fpa_pkg::CMD_DEC: smp[0] = a_w - ONE;
            fpa_pkg::CMD_MIN: smp[0] = (a_w > b_w) ? b_w : a_w;
            fpa_pkg::CMD_MAX: smp[0] = (a_w < b_w) ? b_w : a_w;
            default:          smp[0] = {W{1'b0}};
        endcase
        ma[0]  = a_w[W-1] ? (W'(~a_w) + ONE) : a_w;
        mb[0]  = b_w[W-1] ? (W'(~b_w) + ONE) : b_w;
        hi[0]  = {W{1'b0}};
        lo[0]  = mb[0];
        rem[0] = {W{1'b0}};
        dq[0]  = {ma[0], {FRACTION_BITS{1'b0}}};
        v[0]   = operands.valid;
    end

    assign operands.ready = rdy[0];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            assign rdy[i] = !v[i+1] || rdy[i+1];

            fpa_cell #(
                .WORD_WIDTH    (W),
                .FRACTION_BITS (FRACTION_BITS),
                .DO_MUL        (i < W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (rdy[i]),
                .valid_in  (v[i]),
                .ctl_in    (ctl[i]),
                .simple_in (smp[i]),
                .ma_in     (ma[i]),
                .mb_in     (mb[i]),
                .hi_in     (hi[i]),
                .lo_in     (lo[i]),
                .rem_in    (rem[i]),
                .dq_in     (dq[i]),
                .valid     (v[i+1]),
                .ctl       (ctl[i+1]),
                .simple    (smp[i+1]),
                .ma        (ma[i+1]),
                .mb        (mb[i+1]),
                .hi        (hi[i+1]),
                .lo        (lo[i+1]),
                .rem       (rem[i+1]),
                .dq        (dq[i+1])
            );
        end
    endgenerate

    fpa_finish #(
        .WORD_WIDTH    (W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v[N]),
        .ctl_in    (ctl[N]),
        .simple_in (smp[N]),
        .hi_in     (hi[N]),
        .lo_in     (lo[N]),
        .dq_in     (dq[N]),
        .take      (rdy[N]),
        .results   (results)
    );

endmodule

// ===== hdl/fpa_cell.sv =====
// One cell of the arithmetic chain: a shift-add multiply step (if DO_MUL)
// and a restoring divide step on the transaction it holds. Depends on fpa_pkg.
module fpa_cell #(
    parameter int unsigned WORD_WIDTH    = 32,
    parameter int unsigned FRACTION_BITS = 8,
    parameter bit          DO_MUL        = 1'b1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic                                 valid_in,
    input  fpa_pkg::ctl_t                        ctl_in,
    input  logic [WORD_WIDTH-1:0]                simple_in,
    input  logic [WORD_WIDTH-1:0]                ma_in,
    input  logic [WORD_WIDTH-1:0]                mb_in,
    input  logic [WORD_WIDTH-1:0]                hi_in,
    input  logic [WORD_WIDTH-1:0]                lo_in,
    input  logic [WORD_WIDTH-1:0]                rem_in,
    input  logic [WORD_WIDTH+FRACTION_BITS-1:0]  dq_in,
    output logic                                 valid,
    output fpa_pkg::ctl_t                        ctl,
    output logic [WORD_WIDTH-1:0]                simple,
    output logic [WORD_WIDTH-1:0]                ma,
    output logic [WORD_WIDTH-1:0]                mb,
    output logic [WORD_WIDTH-1:0]                hi,
    output logic [WORD_WIDTH-1:0]                lo,
    output logic [WORD_WIDTH-1:0]                rem,
    output logic [WORD_WIDTH+FRACTION_BITS-1:0]  dq
);

    localparam int unsigned W  = WORD_WIDTH;
    localparam int unsigned DW = WORD_WIDTH + FRACTION_BITS;

    logic                  valid_reg;
    fpa_pkg::ctl_t         ctl_reg;
    logic [W-1:0]          simple_reg;
    logic [W-1:0]          ma_reg;
    logic [W-1:0]          mb_reg;
    logic [W-1:0]          hi_reg;
    logic [W-1:0]          hi_next;
    logic [W-1:0]          lo_reg;
    logic [W-1:0]          lo_next;
    logic [W-1:0]          rem_reg;
    logic [W-1:0]          rem_next;
    logic [DW-1:0]         dq_reg;
    logic [DW-1:0]         dq_next;
    logic [W:0]            sum;
    logic [W:0]            shifted;
    logic [W:0]            diff;
    logic                  fits;

    always_comb
    begin
        sum = {1'b0, hi_in} + (lo_in[0] ? {1'b0, ma_in} : {(W+1){1'b0}});
        if (DO_MUL)
        begin
            hi_next = sum[W:1];
            lo_next = {sum[0], lo_in[W-1:1]};
        end
        else
        begin
            hi_next = hi_in;
            lo_next = lo_in;
        end
        shifted  = {rem_in, dq_in[DW-1]};
        diff     = shifted - {1'b0, mb_in};
        fits     = shifted >= {1'b0, mb_in};
        rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
        dq_next  = {dq_in[DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg    <= ctl_in;
            simple_reg <= simple_in;
            ma_reg     <= ma_in;
            mb_reg     <= mb_in;
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
            rem_reg    <= rem_next;
            dq_reg     <= dq_next;
        end
    end

    assign valid  = valid_reg;
    assign ctl    = ctl_reg;
    assign simple = simple_reg;
    assign ma     = ma_reg;
    assign mb     = mb_reg;
    assign hi     = hi_reg;
    assign lo     = lo_reg;
    assign rem    = rem_reg;
    assign dq     = dq_reg;

endmodule

// ===== hdl/fpa_finish.sv =====
// Output stage: signs the product and quotient, picks the result by command
// and holds it in the output register. Depends on fpa_pkg and fpa_if.
module fpa_finish #(
    parameter int unsigned WORD_WIDTH    = 32,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 valid_in,
    input  fpa_pkg::ctl_t                        ctl_in,
    input  logic [WORD_WIDTH-1:0]                simple_in,
    input  logic [WORD_WIDTH-1:0]                hi_in,
    input  logic [WORD_WIDTH-1:0]                lo_in,
    input  logic [WORD_WIDTH+FRACTION_BITS-1:0]  dq_in,
    output logic                                 take,
    fpa_out_if.source                            results
);

    localparam int unsigned W = WORD_WIDTH;
    localparam int unsigned F = FRACTION_BITS;

    logic [2*W-1:0]                     prod;
    logic [2*W-1:0]                     prod_s;
    logic [W-1:0]                       quot;
    logic signed [W-1:0]                res_w;
    logic                               valid_reg;
    logic signed [fpa_pkg::FIELD_WIDTH-1:0] result_reg;
    logic signed [fpa_pkg::FIELD_WIDTH-1:0] result_next;
    logic                               gt_reg;
    logic                               lt_reg;
    logic                               eq_reg;

    assign take = !valid_reg || results.ready;

    always_comb
    begin
        prod   = {hi_in, lo_in};
        prod_s = ctl_in.neg ? ((2*W)'(~prod) + (2*W)'(1)) : prod;
        quot   = ctl_in.neg ? (W'(~dq_in[W-1:0]) + W'(1)) : dq_in[W-1:0];
        case (ctl_in.cmd)
            fpa_pkg::CMD_MUL: res_w = prod_s[F+W-1:F];
            fpa_pkg::CMD_DIV: res_w = ctl_in.b_zero ? {W{1'b0}} : quot;
            default:          res_w = simple_in;
        endcase
        result_next = fpa_pkg::FIELD_WIDTH'(res_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && valid_in)
        begin
            result_reg <= result_next;
            gt_reg     <= ctl_in.gt;
            lt_reg     <= ctl_in.lt;
            eq_reg     <= ctl_in.eq;
        end
    end

    assign results.valid     = valid_reg;
    assign results.result    = result_reg;
    assign results.a_greater = gt_reg;
    assign results.a_less    = lt_reg;
    assign results.a_equal   = eq_reg;

endmodule

// ===== hdl/fpa_checker.sv =====
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and fixed_point_alu.
module fpa_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   results_valid,
    input logic                                   results_ready,
    input logic signed [fpa_pkg::FIELD_WIDTH-1:0] result,
    input logic                                   a_greater,
    input logic                                   a_less,
    input logic                                   a_equal
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !results_valid)
        else $error("Result transaction offered during reset.");

    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid |-> $onehot({a_greater, a_less, a_equal}))
        else $error("Comparison flags are not exactly one-hot.");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> results_valid)
        else $error("Stalled result transaction was withdrawn.");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=>
            $stable(result) && $stable({a_greater, a_less, a_equal}))
        else $error("Stalled result transaction changed.");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .results_valid (results.valid),
    .results_ready (results.ready),
    .result        (results.result),
    .a_greater     (results.a_greater),
    .a_less        (results.a_less),
    .a_equal       (results.a_equal)
);
